// ----- hdl/khlc_pkg.sv -----
// Package for the hygrometer log conversion: widths, reset values, register codes
// and the log tables that are worked out at elaboration. No dependencies.

package khlc_pkg;

  localparam int unsigned LOG_SEGMENTS = 64;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned X_W      = 23;
  localparam int unsigned E_W      = 5;
  localparam int unsigned E_N      = 23;
  localparam int unsigned FRAC_W   = 23;
  localparam int unsigned KW       = $clog2(LOG_SEGMENTS);
  localparam int unsigned POS_W    = FRAC_W + KW;
  localparam int unsigned TAB_W    = 16;
  localparam int unsigned DR_W     = TAB_W + FRAC_W;
  localparam int unsigned LNV_W    = 22;
  localparam int unsigned REF_W    = 23;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned BIAS_W   = 24;
  localparam int unsigned DIFF_W   = 24;
  localparam int unsigned PROD_W   = DIFF_W + GAIN_W;
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned MIN_UV = 100;
  localparam logic [63:0] LN2_Q30    = 64'd744261118;
  localparam logic [63:0] LN1000_Q16 = 64'd452707;

  localparam logic signed [REF_W-1:0]  LOG_REF_RST  = 23'sd558183;
  localparam logic signed [GAIN_W-1:0] GAIN_RST     = -24'sd336082;
  localparam logic signed [BIAS_W-1:0] BIAS_RST     = 24'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_REF       = 2'd0,
    CFG_INV_PATH_GAIN = 2'd1,
    CFG_BIAS          = 2'd2
  } cfg_idx_e;

  typedef logic [TAB_W-1:0] tab_t [LOG_SEGMENTS];
  typedef logic signed [LNV_W-1:0] eln_t [E_N];

  // shift-subtract quotient, elaboration only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + k/LOG_SEGMENTS) in Q.16 from a Q.30 atanh series
  function automatic logic [63:0] ln_knot(input int unsigned k);
    logic [63:0] b;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] n;
    b    = 64'(LOG_SEGMENTS);
    z    = udiv(64'(k) << 30, 2 * b + 64'(k));
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    n    = 64'd1;
    for (int i = 0; i < 40; i++) begin
      if (term != '0) begin
        sum  = sum + udiv(term, n);
        term = (term * z2) >> 30;
        n    = n + 64'd2;
      end
    end
    return (2 * sum + 64'd8192) >> 14;
  endfunction

  function automatic tab_t build_base();
    tab_t t;
    for (int unsigned k = 0; k < LOG_SEGMENTS; k++) begin
      t[k] = TAB_W'(ln_knot(k));
    end
    return t;
  endfunction

  function automatic tab_t build_delta();
    tab_t t;
    logic [63:0] lo;
    logic [63:0] hi;
    for (int unsigned k = 0; k < LOG_SEGMENTS; k++) begin
      lo = ln_knot(k);
      hi = ln_knot(k + 1);
      t[k] = (hi > lo) ? TAB_W'(hi - lo) : '0;
    end
    return t;
  endfunction

  // round(e * ln2) - ln(1000), Q.16
  function automatic eln_t build_eln();
    eln_t t;
    logic [63:0] v;
    for (int unsigned e = 0; e < E_N; e++) begin
      v    = (64'(e) * LN2_Q30 + 64'd8192) >> 14;
      t[e] = LNV_W'(v) - LNV_W'(LN1000_Q16);
    end
    return t;
  endfunction

  localparam tab_t LOG_BASE  = build_base();
  localparam tab_t LOG_DELTA = build_delta();
  localparam eln_t EXP_LN    = build_eln();

endpackage

// ----- hdl/khlc_if.sv -----
// Valid/ready channel interfaces for the sample input and the density output.
// Depends on khlc_pkg for field widths.

interface khlc_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [khlc_pkg::SAMPLE_W-1:0]       sample_microvolts;

  modport source (output valid, output sample_microvolts, input ready);
  modport sink   (input valid, input sample_microvolts, output ready);
endinterface

interface khlc_out_if;
  logic                                       valid;
  logic                                       ready;
  logic [khlc_pkg::OUT_W-1:0]                 vapour_density;
  logic                                       saturated;

  modport source (output valid, output vapour_density, output saturated, input ready);
  modport sink   (input valid, input vapour_density, input saturated, output ready);
endinterface

// ----- hdl/krypton_humidity_log_convert.sv -----
// Hygrometer log conversion top level: six-stage pipeline from a microvolt
// sample to Q8.16 vapour density. Depends on khlc_pkg and khlc_if.sv.
//
//   channel   dir  handshake        payload
//   in_i      in   valid/ready      sample_microvolts (s24, uV)
//   out_o     out  valid/ready      vapour_density (u24 Q8.16), saturated
//   cfg       in   cfg_we_i         cfg_idx_i, cfg_wdata_i (write only)
//
// One beat per cycle sustained while out_o.ready holds; a beat passes from input to
// output through the stages in order: clamp and leading-one, normalize and table
// read, interpolation multiply, log difference, gain multiply, round/clamp.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse under a stall. Reset clears the stage valid bits and loads the
// register defaults.

module krypton_humidity_log_convert (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  khlc_in_if.sink                               in_i,
  khlc_out_if.source                            out_o,
  input  logic                                  cfg_we_i,
  input  logic [khlc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [khlc_pkg::CFG_W-1:0]            cfg_wdata_i
);

  logic signed [khlc_pkg::REF_W-1:0]  log_ref_q;
  logic signed [khlc_pkg::GAIN_W-1:0] gain_q;
  logic signed [khlc_pkg::BIAS_W-1:0] bias_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_ref_q <= khlc_pkg::LOG_REF_RST;
      gain_q    <= khlc_pkg::GAIN_RST;
      bias_q    <= khlc_pkg::BIAS_RST;
    end else if (cfg_we_i) begin
      case (khlc_pkg::cfg_idx_e'(cfg_idx_i))
        khlc_pkg::CFG_LOG_REF:       log_ref_q <= cfg_wdata_i[khlc_pkg::REF_W-1:0];
        khlc_pkg::CFG_INV_PATH_GAIN: gain_q    <= cfg_wdata_i[khlc_pkg::GAIN_W-1:0];
        khlc_pkg::CFG_BIAS:          bias_q    <= cfg_wdata_i[khlc_pkg::BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || out_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // stage 1: clamp low samples, find leading one
  logic [khlc_pkg::X_W-1:0] x1_d, x1_q;
  logic [khlc_pkg::E_W-1:0] e1_d, e1_q;

  always_comb begin
    if (in_i.sample_microvolts < $signed(khlc_pkg::SAMPLE_W'(khlc_pkg::MIN_UV))) begin
      x1_d = khlc_pkg::X_W'(khlc_pkg::MIN_UV);
    end else begin
      x1_d = in_i.sample_microvolts[khlc_pkg::X_W-1:0];
    end
    e1_d = '0;
    for (int i = 0; i < khlc_pkg::X_W; i++) begin
      if (x1_d[i]) e1_d = khlc_pkg::E_W'(i);
    end
  end

  // stage 2: normalize mantissa, segment lookup
  logic [khlc_pkg::X_W:0]           mn2;
  logic [khlc_pkg::POS_W-1:0]       pos2;
  logic [khlc_pkg::KW-1:0]          k2;
  logic [khlc_pkg::E_W-1:0]         e2_q;
  logic [khlc_pkg::TAB_W-1:0]       base2_q, dk2_q;
  logic [khlc_pkg::FRAC_W-1:0]      r2_q;

  assign mn2  = (khlc_pkg::X_W + 1)'(x1_q) << (khlc_pkg::E_W'(khlc_pkg::X_W) - e1_q);
  assign pos2 = khlc_pkg::POS_W'(mn2[khlc_pkg::FRAC_W-1:0])
              * khlc_pkg::POS_W'(khlc_pkg::LOG_SEGMENTS);
  assign k2   = pos2[khlc_pkg::POS_W-1:khlc_pkg::FRAC_W];

  // stage 3: interpolation product, exponent term
  logic [khlc_pkg::DR_W-1:0]          dr3_q;
  logic signed [khlc_pkg::LNV_W-1:0]  base3_q;

  // stage 4: ln(mV) - log_ref
  logic [khlc_pkg::DR_W:0]            rnd4;
  logic signed [khlc_pkg::DIFF_W-1:0] diff4_d, diff4_q;

  assign rnd4    = (khlc_pkg::DR_W + 1)'(dr3_q) + (khlc_pkg::DR_W + 1)'(1 << 22);
  assign diff4_d = {{(khlc_pkg::DIFF_W - khlc_pkg::LNV_W){base3_q[khlc_pkg::LNV_W-1]}}, base3_q}
                 + khlc_pkg::DIFF_W'(rnd4[khlc_pkg::DR_W:khlc_pkg::FRAC_W])
                 - {{(khlc_pkg::DIFF_W - khlc_pkg::REF_W){log_ref_q[khlc_pkg::REF_W-1]}},
                    log_ref_q};

  // stage 5: gain product
  logic signed [khlc_pkg::PROD_W-1:0] prod5_q;

  // stage 6: round to Q.16, subtract bias, clamp
  logic signed [khlc_pkg::PROD_W:0]   t6;
  logic signed [khlc_pkg::PROD_W-16:0] q6;
  logic signed [khlc_pkg::PROD_W-15:0] h6;
  logic [khlc_pkg::OUT_W-1:0]         dens6_d, dens6_q;
  logic                               sat6_d, sat6_q;

  assign t6 = {prod5_q[khlc_pkg::PROD_W-1], prod5_q} + (khlc_pkg::PROD_W + 1)'(32768);
  assign q6 = t6[khlc_pkg::PROD_W:16];
  assign h6 = {q6[khlc_pkg::PROD_W-16], q6}
            - {{(khlc_pkg::PROD_W - 14 - khlc_pkg::BIAS_W){bias_q[khlc_pkg::BIAS_W-1]}}, bias_q};

  always_comb begin
    dens6_d = h6[khlc_pkg::OUT_W-1:0];
    sat6_d  = 1'b0;
    if (h6 < 0) begin
      dens6_d = '0;
    end else if (h6 > $signed((khlc_pkg::PROD_W - 14)'({khlc_pkg::OUT_W{1'b1}}))) begin
      dens6_d = '1;
      sat6_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      x1_q <= x1_d;
      e1_q <= e1_d;
    end
    if (en2) begin
      e2_q    <= e1_q;
      base2_q <= khlc_pkg::LOG_BASE[k2];
      dk2_q   <= khlc_pkg::LOG_DELTA[k2];
      r2_q    <= pos2[khlc_pkg::FRAC_W-1:0];
    end
    if (en3) begin
      dr3_q   <= khlc_pkg::DR_W'(dk2_q) * khlc_pkg::DR_W'(r2_q);
      base3_q <= khlc_pkg::EXP_LN[e2_q]
               + $signed({{(khlc_pkg::LNV_W - khlc_pkg::TAB_W){1'b0}}, base2_q});
    end
    if (en4) begin
      diff4_q <= diff4_d;
    end
    if (en5) begin
      prod5_q <= khlc_pkg::PROD_W'(diff4_q) * khlc_pkg::PROD_W'(gain_q);
    end
    if (en6) begin
      dens6_q <= dens6_d;
      sat6_q  <= sat6_d;
    end
  end

  assign out_o.valid          = v6_q;
  assign out_o.vapour_density = dens6_q;
  assign out_o.saturated      = sat6_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v1_q)
    else $error("accepted beat did not enter stage 1");

  a_clamp_floor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> x1_q >= khlc_pkg::X_W'(khlc_pkg::MIN_UV))
    else $error("clamped sample below floor");

  a_sat_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |-> out_o.vapour_density == '1)
    else $error("saturated beat without full-scale density");

  a_stall_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && v6_q && !out_o.ready |=> v5_q && v6_q)
    else $error("stalled pipeline dropped a beat");

endmodule
